// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Depends on nothing; included by the files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

// ===== design/crlf_pkg.sv =====
// Shared constants and types of the CR/LF frame deframer.
// No dependencies; imported by all deframer modules.
`timescale 1ns / 1ps
`default_nettype none
package crlf_pkg;

    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;
    localparam int PAYLOAD_BYTES_DEF = 24;
    localparam int IDX_W  = 3;
    localparam int WORD_W = 32;

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_WAITLF = 5'b00010,
        PH_PAY    = 5'b00100,
        PH_FTLF   = 5'b01000,
        PH_FTCR   = 5'b10000
    } phase_t;

    // frame handed from parser to emitter: which buffer holds it
    typedef struct packed {
        logic bank;
    } frame_cmd_t;

    // emitter tells parser a buffer has been read out
    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

endpackage
`default_nettype wire

// ===== design/crlf_framed_payload_deframer_core.sv =====
// CR/LF framed payload deframer, top level.
// Depends on crlf_pkg, crlf_front, crlf_cmdq, crlf_back and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Takes one received byte per cycle on the s_ side and looks for frames of
// 0x0D 0x0A, PAYLOAD_BYTES payload bytes, 0x0A 0x0D. Payload bytes are packed
// little-endian into 32-bit words and written into one of two frame buffers;
// the closing 0x0D queues the frame, and the emitter sends its PAYLOAD_BYTES/4
// words on consecutive cycles while m_tready is high, after the queue and the
// read and output stages, the last one with m_tlast. Bytes keep flowing one per
// cycle meanwhile; the input stalls only if a third frame's payload starts while
// both buffers hold unsent frames, which m_tready backpressure alone can cause.
// word_index sits in m_tdata[2:0], payload_word in m_tdata[34:3].
module crlf_framed_payload_deframer_core #(
    parameter int PAYLOAD_BYTES = crlf_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // word_index[2:0], payload_word[34:3]
    output logic             m_tlast    // last_word
);
    import crlf_pkg::*;

    localparam int NUM_WORDS = PAYLOAD_BYTES / 4;
    localparam int WA = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int AW = WA + 1;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              cmd_push, cmd_pop, cmd_valid, cmd_full;
    frame_cmd_t        push_cmd, head_cmd;
    release_t          rel;

    crlf_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES),
        .AW(AW)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .cmd_push(cmd_push),
        .cmd(push_cmd),
        .rel(rel)
    );

    crlf_cmdq u_cmdq (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(cmd_push),
        .push_cmd(push_cmd),
        .pop(cmd_pop),
        .not_empty(cmd_valid),
        .full(cmd_full),
        .head(head_cmd)
    );

    crlf_back #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES),
        .AW(AW)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .cmd_valid(cmd_valid),
        .cmd(head_cmd),
        .cmd_pop(cmd_pop),
        .rel(rel),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    // buffer ownership must keep the frame queue from overflowing
    `ASSERT_NEVER(a_cmdq_overflow, aclk, aresetn, cmd_push && cmd_full)
    `ASSERT_CLK(a_last_index, aclk, aresetn,
        (m_tvalid && m_tlast) |-> (m_tdata[2:0] == IDX_W'(NUM_WORDS - 1)))
    // words of one frame follow without gaps and with rising index
    `ASSERT_CLK(a_word_follows, aclk, aresetn,
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1))

endmodule
`default_nettype wire

// ===== design/crlf_front.sv =====
// Byte parser: hunts headers, packs payload words into the frame buffers.
// Depends on crlf_pkg; drives the buffer write port and the frame queue.
`timescale 1ns / 1ps
`default_nettype none
module crlf_front #(
    parameter int PAYLOAD_BYTES = crlf_pkg::PAYLOAD_BYTES_DEF,
    parameter int AW = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [crlf_pkg::WORD_W-1:0]   wr_data,
    output logic                          cmd_push,
    output crlf_pkg::frame_cmd_t          cmd,
    input  crlf_pkg::release_t            rel
);
    import crlf_pkg::*;

    localparam int NUM_WORDS = PAYLOAD_BYTES / 4;
    localparam int WORD_END  = NUM_WORDS * 4;
    localparam int WA = AW - 1;
    localparam int PW = $clog2(PAYLOAD_BYTES);

    phase_t              phase_reg, phase_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [WA-1:0]       wcnt_reg, wcnt_next;
    logic [WORD_W-1:0]   shift_reg, shift_next;
    logic                bank_reg, bank_next;
    logic [1:0]          busy_reg, busy_next;
    logic                accept;

    // stall only when payload would land in a buffer not yet read out
    assign s_tready = !(phase_reg == PH_PAY && busy_reg[bank_reg]);
    assign accept   = s_tvalid && s_tready;
    assign wr_addr  = {bank_reg, wcnt_reg};
    assign wr_data  = {s_tdata, shift_reg[WORD_W-1:8]};
    assign cmd.bank = bank_reg;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        wcnt_next  = wcnt_reg;
        shift_next = shift_reg;
        bank_next  = bank_reg;
        wr_en      = 1'b0;
        cmd_push   = 1'b0;
        if (accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (s_tdata == CR_BYTE) phase_next = PH_WAITLF;
                end
                PH_WAITLF: begin
                    if (s_tdata == LF_BYTE) begin
                        pos_next   = '0;
                        wcnt_next  = '0;
                        phase_next = PH_PAY;
                    end else if (s_tdata != CR_BYTE) begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAY: begin
                    shift_next = {s_tdata, shift_reg[WORD_W-1:8]};
                    // trailing bytes past the last whole word are dropped
                    if (pos_reg[1:0] == 2'b11 && int'(pos_reg) < WORD_END) begin
                        wr_en     = 1'b1;
                        wcnt_next = wcnt_reg + 1'b1;
                    end
                    if (pos_reg == PW'(PAYLOAD_BYTES - 1)) begin
                        pos_next   = '0;
                        phase_next = PH_FTLF;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                PH_FTLF: begin
                    phase_next = (s_tdata == LF_BYTE) ? PH_FTCR : PH_HUNT;
                end
                PH_FTCR: begin
                    if (s_tdata == CR_BYTE) begin
                        cmd_push  = 1'b1;
                        bank_next = ~bank_reg;
                    end
                    phase_next = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        busy_next = busy_reg;
        if (rel.valid) busy_next[rel.bank] = 1'b0;
        if (cmd_push)  busy_next[bank_reg] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            wcnt_reg  <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            wcnt_reg  <= wcnt_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

endmodule
`default_nettype wire

// ===== design/crlf_cmdq.sv =====
// Two-entry queue of finished frames between parser and emitter.
// Depends on crlf_pkg for the frame command type.
`timescale 1ns / 1ps
`default_nettype none
module crlf_cmdq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  crlf_pkg::frame_cmd_t     push_cmd,
    input  wire logic                pop,
    output logic                     not_empty,
    output logic                     full,
    output crlf_pkg::frame_cmd_t     head
);
    import crlf_pkg::*;

    frame_cmd_t  entry_reg [2];
    logic        rd_ptr_reg, rd_ptr_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

// ===== design/crlf_back.sv =====
// Word emitter: owns the two frame buffers and streams a frame's words out.
// Depends on crlf_pkg; fed by crlf_front writes and crlf_cmdq commands.
`timescale 1ns / 1ps
`default_nettype none
module crlf_back #(
    parameter int PAYLOAD_BYTES = crlf_pkg::PAYLOAD_BYTES_DEF,
    parameter int AW = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic [crlf_pkg::WORD_W-1:0] wr_data,
    input  wire logic                     cmd_valid,
    input  crlf_pkg::frame_cmd_t          cmd,
    output logic                          cmd_pop,
    output crlf_pkg::release_t            rel,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [39:0]                   m_tdata,  // word_index[2:0], payload_word[34:3]
    output logic                          m_tlast   // last_word
);
    import crlf_pkg::*;

    localparam int NUM_WORDS = PAYLOAD_BYTES / 4;
    localparam int WA = AW - 1;

    logic [WORD_W-1:0] mem [2**AW];

    logic              active_reg, active_next;
    logic              bank_reg, bank_next;
    logic [WA-1:0]     k_reg, k_next;
    logic              advance, issue, issue_last;
    release_t          rel_reg, rel_next;

    // read stage
    logic              rv_reg;
    logic [IDX_W-1:0]  ridx_reg;
    logic              rlast_reg;
    logic [WORD_W-1:0] rdata_reg;

    // output stage
    logic              ov_reg;
    logic [IDX_W-1:0]  oidx_reg;
    logic              olast_reg;
    logic [WORD_W-1:0] odata_reg;

    // whole read/output pipe moves together when the output is free
    assign advance    = !ov_reg || m_tready;
    assign issue      = active_reg && advance;
    assign issue_last = (k_reg == WA'(NUM_WORDS - 1));
    assign cmd_pop    = !active_reg && cmd_valid;
    assign rel        = rel_reg;

    always_comb begin
        active_next = active_reg;
        bank_next   = bank_reg;
        k_next      = k_reg;
        rel_next    = '0;
        if (cmd_pop) begin
            active_next = 1'b1;
            bank_next   = cmd.bank;
            k_next      = '0;
        end else if (issue) begin
            k_next = k_reg + 1'b1;
            if (issue_last) begin
                active_next    = 1'b0;
                rel_next.valid = 1'b1;
                rel_next.bank  = bank_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            bank_reg   <= 1'b0;
            k_reg      <= '0;
            rel_reg    <= '0;
            rv_reg     <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            active_reg <= active_next;
            bank_reg   <= bank_next;
            k_reg      <= k_next;
            rel_reg    <= rel_next;
            if (advance) begin
                rv_reg <= issue;
                ov_reg <= rv_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rdata_reg <= mem[{bank_reg, k_reg}];
            ridx_reg  <= IDX_W'(k_reg);
            rlast_reg <= issue_last;
            odata_reg <= rdata_reg;
            oidx_reg  <= ridx_reg;
            olast_reg <= rlast_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {5'b0, odata_reg, oidx_reg};
    assign m_tlast  = olast_reg;

endmodule
`default_nettype wire

// ===== tb/crlf_deframe_checker.sv =====
// Checker for the CR/LF frame deframer: watches both stream channels,
// predicts the payload words from the accepted bytes and compares them in order.
// Depends on crlf_pkg.
`timescale 1ns / 1ps
module crlf_deframe_checker #(
    parameter int PAYLOAD_BYTES = crlf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte[7:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // word_index[2:0], payload_word[34:3]
    input  logic        m_tlast,    // last_word
    output int          err_count,
    output int          pending
);
    import crlf_pkg::*;

    localparam int NUM_WORDS = PAYLOAD_BYTES / 4;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] data;
        logic              last;
    } pay_word_t;

    phase_t            frame_phase;
    int                pay_count;
    logic [7:0]        pay_bytes [PAYLOAD_BYTES];
    pay_word_t         expected_words [$];
    pay_word_t         want;
    logic [IDX_W-1:0]  got_idx;
    logic [WORD_W-1:0] got_data;

    initial begin
        err_count = 0;
        pending   = 0;
    end

    task automatic queue_frame_words();
        pay_word_t w;
        for (int k = 0; k < NUM_WORDS; k++) begin
            w.idx  = IDX_W'(k);
            w.data = {pay_bytes[4*k+3], pay_bytes[4*k+2], pay_bytes[4*k+1], pay_bytes[4*k]};
            w.last = (k == NUM_WORDS - 1);
            expected_words.push_back(w);
        end
    endtask

    task automatic track_rx_byte(input logic [7:0] b);
        case (frame_phase)
            PH_HUNT: begin
                frame_phase = (b == CR_BYTE) ? PH_WAITLF : PH_HUNT;
            end
            PH_WAITLF: begin
                // extra CRs keep waiting for the LF
                if (b == LF_BYTE) begin
                    pay_count   = 0;
                    frame_phase = PH_PAY;
                end else if (b != CR_BYTE) begin
                    frame_phase = PH_HUNT;
                end
            end
            PH_PAY: begin
                pay_bytes[pay_count] = b;
                pay_count++;
                if (pay_count >= PAYLOAD_BYTES) begin
                    pay_count   = 0;
                    frame_phase = PH_FTLF;
                end
            end
            PH_FTLF: begin
                frame_phase = (b == LF_BYTE) ? PH_FTCR : PH_HUNT;
            end
            PH_FTCR: begin
                if (b == CR_BYTE)
                    queue_frame_words();
                frame_phase = PH_HUNT;
            end
            default: begin
                frame_phase = PH_HUNT;
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_phase = PH_HUNT;
            pay_count   = 0;
            expected_words.delete();
        end else begin
            if (s_tvalid && s_tready)
                track_rx_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                got_idx  = m_tdata[2:0];
                got_data = m_tdata[34:3];
                if (expected_words.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("ERROR: unexpected word idx=%0d data=%08h last=%b",
                                 got_idx, got_data, m_tlast);
                end else begin
                    want = expected_words.pop_front();
                    if (got_idx !== want.idx || got_data !== want.data
                            || m_tlast !== want.last) begin
                        err_count++;
                        if (err_count <= MAX_SHOWN)
                            $display({"ERROR: word mismatch exp idx=%0d data=%08h last=%b,",
                                      " got idx=%0d data=%08h last=%b"},
                                     want.idx, want.data, want.last,
                                     got_idx, got_data, m_tlast);
                    end
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

// ===== tb/tb_crlf_framed_payload_deframer_core.sv =====
// Testbench top for crlf_framed_payload_deframer_core: drives byte streams of
// good, broken and noisy frames with random gaps and stalls; verdict from the checker.
// Depends on crlf_pkg, crlf_deframe_checker and the deframer RTL.
`timescale 1ns / 1ps
module tb_crlf_framed_payload_deframer_core;
    import crlf_pkg::*;

    localparam int PAY          = PAYLOAD_BYTES_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum int {
        FR_GOOD,
        FR_BAD_HDR,
        FR_BAD_FOOT_LF,
        FR_BAD_CLOSE,
        FR_NOISE
    } frame_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // rx_byte[7:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // word_index[2:0], payload_word[34:3]
    logic        m_tlast;    // last_word

    int err_count;
    int pending;
    int cycles = 0;
    int bytes_sent = 0;
    bit rx_gaps_on = 1'b0;
    bit tx_stalls_on = 1'b0;
    bit m_took = 1'b0;
    int m_stall_left = 0;

    crlf_framed_payload_deframer_core #(.PAYLOAD_BYTES(PAY)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    crlf_deframe_checker #(.PAYLOAD_BYTES(PAY)) chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .err_count (err_count),
        .pending   (pending)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: new stall drawn after every accepted word
    always @(posedge aclk)
        m_took <= m_tvalid && m_tready;

    always @(negedge aclk) begin
        if (m_took)
            m_stall_left = tx_stalls_on ? $urandom_range(0, 11) : 0;
        if (m_stall_left != 0) begin
            m_tready <= 1'b0;
            m_stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = rx_gaps_on ? $urandom_range(0, 11) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // stop sending and wait until every predicted word has come out
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] rand_payload_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return CR_BYTE;
            3:       return LF_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_other_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CR_BYTE || b == LF_BYTE);
        return b;
    endfunction

    task automatic send_header(input int n_cr);
        repeat (n_cr) send_byte(CR_BYTE);
        send_byte(LF_BYTE);
    endtask

    // directed payload: all-zero word, all-one word, CR/LF inside data, then a ramp
    task automatic send_payload(input bit directed);
        logic [7:0] b;
        for (int i = 0; i < PAY; i++) begin
            if (!directed)
                b = rand_payload_byte();
            else if (i < 4)
                b = 8'h00;
            else if (i < 8)
                b = 8'hFF;
            else if (i < 12)
                b = i[0] ? LF_BYTE : CR_BYTE;
            else
                b = 8'(i * 37 + 1);
            send_byte(b);
        end
    endtask

    task automatic send_frame(input frame_kind_t kind);
        case (kind)
            FR_GOOD: begin
                send_header($urandom_range(1, 3));
                send_payload(1'b0);
                send_byte(LF_BYTE);
                send_byte(CR_BYTE);
            end
            FR_BAD_HDR: begin
                repeat ($urandom_range(1, 2)) send_byte(CR_BYTE);
                send_byte(rand_other_byte());
            end
            FR_BAD_FOOT_LF: begin
                send_header(1);
                send_payload(1'b0);
                // a CR here must not count as a new header byte
                send_byte($urandom_range(0, 1) ? CR_BYTE : rand_other_byte());
            end
            FR_BAD_CLOSE: begin
                send_header(1);
                send_payload(1'b0);
                send_byte(LF_BYTE);
                send_byte($urandom_range(0, 1) ? LF_BYTE : rand_other_byte());
            end
            default: begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        endcase
    endtask

    task automatic run_random_frames(input int n_bytes);
        int stop_at;
        int r;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(0, 9);
            if (r <= 5)
                send_frame(FR_GOOD);
            else if (r == 6)
                send_frame(FR_BAD_HDR);
            else if (r == 7)
                send_frame(FR_BAD_FOOT_LF);
            else if (r == 8)
                send_frame(FR_BAD_CLOSE);
            else
                send_frame(FR_NOISE);
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        m_tready = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: noise in hunt, bad LF, repeated CRs, extreme payload
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(LF_BYTE);
        send_byte(CR_BYTE);
        send_byte(8'h41);
        send_header(3);
        send_payload(1'b1);
        send_byte(LF_BYTE);
        send_byte(CR_BYTE);
        // CR in place of footer LF, then an LF that must not open a frame
        send_header(1);
        send_payload(1'b0);
        send_byte(CR_BYTE);
        send_byte(LF_BYTE);
        // footer LF followed by a non-CR closing byte
        send_header(1);
        send_payload(1'b0);
        send_byte(LF_BYTE);
        send_byte(LF_BYTE);
        send_frame(FR_GOOD);

        rx_gaps_on   = 1'b1;
        tx_stalls_on = 1'b1;
        run_random_frames(50);
        wait_drained();

        // back-to-back bytes against a stalling receiver
        rx_gaps_on = 1'b0;
        run_random_frames(50);

        rx_gaps_on   = 1'b1;
        tx_stalls_on = 1'b0;
        run_random_frames(50);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
